// ----- rtl/core/vdcw_pkg.sv -----
// Shared types and constants for the vector DMA command walker.
`timescale 1ns / 1ps
`default_nettype none

package vdcw_pkg;

    // Word field layout
    localparam int WORD_W = 32;
    localparam int CMD_W  = 7;
    localparam int NUM_W  = 8;
    localparam int IMM_W  = 16;
    localparam int LEN_W  = 18;
    localparam int IDX_W  = 5;
    localparam int KIND_W = 2;

    // Result kinds
    localparam logic [KIND_W-1:0] KIND_COMMAND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [KIND_W-1:0] KIND_IGNORED = 2'd2;

    // Command codes (word[30:24])
    localparam logic [CMD_W-1:0] CMD_MASK   = 7'h20;
    localparam logic [CMD_W-1:0] CMD_ROW    = 7'h30;
    localparam logic [CMD_W-1:0] CMD_COL    = 7'h31;
    localparam logic [CMD_W-1:0] CMD_MPG    = 7'h4A;
    localparam logic [CMD_W-1:0] CMD_DIRECT = 7'h50;

    // Unpack decode: unpack class bits and format mask
    localparam logic [CMD_W-1:0] UNPACK_CLASS = 7'h60;
    localparam logic [CMD_W-1:0] UNPACK_MASK  = 7'h6F;
    localparam logic [CMD_W-1:0] UNPACK_V3_32 = 7'h68;
    localparam logic [CMD_W-1:0] UNPACK_V3_16 = 7'h69;
    localparam logic [CMD_W-1:0] UNPACK_V3_8  = 7'h6A;
    localparam logic [CMD_W-1:0] UNPACK_V4_32 = 7'h6C;

    // Decoded fields of one command word
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [NUM_W-1:0] num;
        logic [IMM_W-1:0] imm;
    } cmd_fields_t;

endpackage

`default_nettype wire

// ----- rtl/core/vdcw_len_decode.sv -----
// Payload length decoder for one command word.
`timescale 1ns / 1ps
`default_nettype none

module vdcw_len_decode (
    input  wire vdcw_pkg::cmd_fields_t       fields,
    output logic [vdcw_pkg::LEN_W-1:0]       payload_len
);
    import vdcw_pkg::*;

    logic [CMD_W-1:0] unpack_code;
    logic [9:0]       num_x3;
    logic [10:0]      v3_16_sum;
    logic [10:0]      v3_8_sum;

    // 3*num and the rounded unpack sums
    assign unpack_code = fields.cmd & UNPACK_MASK;
    assign num_x3      = {1'b0, fields.num, 1'b0} + {2'b00, fields.num};
    assign v3_16_sum   = {1'b0, num_x3} + {10'd0, fields.num[0]};
    assign v3_8_sum    = {1'b0, num_x3} + 11'd3;

    // Length table
    always_comb begin
        case (fields.cmd)
            CMD_MASK:   payload_len = LEN_W'(1);
            CMD_ROW,
            CMD_COL:    payload_len = LEN_W'(4);
            CMD_MPG:    payload_len = LEN_W'({fields.num, 1'b0});
            CMD_DIRECT: payload_len = {fields.imm, 2'b00};
            default: begin
                if ((fields.cmd & UNPACK_CLASS) == '0) begin
                    payload_len = '0;
                end else begin
                    case (unpack_code)
                        UNPACK_V3_32: payload_len = LEN_W'(num_x3);
                        UNPACK_V3_16: payload_len = LEN_W'(v3_16_sum[10:1]);
                        UNPACK_V3_8:  payload_len = LEN_W'(v3_8_sum[10:2]);
                        UNPACK_V4_32: payload_len = LEN_W'({fields.num, 2'b00});
                        default:      payload_len = '0;
                    endcase
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/vector_dma_command_walker.sv -----
// Top level of the vector DMA command walker: classifies packet words.
//
// Usage: packet words enter on the s_ channel, one 32-bit word per request,
// with s_tuser high on the first command word of a new packet. Each word
// yields exactly one result request on the m_ channel: its kind (command,
// payload or ignored) in m_tuser, and in m_tdata the latest command code,
// the payload words still expected and the command count of the walk.
// A walk ends after CODES_PER_WALK command words and their payloads; later
// words are reported as ignored until the next start.
// Path: from input request to result through the input register, then the
// result register. Throughput: one word per cycle while m_tready is high,
// set by the single decode-and-update step between the two registers, which also updates
// the walk counters.
// Reset: both stages empty, the walk open with no payload pending, count
// and latest command zero. Words seen before any start are walked as if a
// start had just been given.
// Stall: when m_tready is low the result register holds; the input
// register still takes one more word, then s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module vector_dma_command_walker #(
    parameter int CODES_PER_WALK = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    // s_tdata: [31:0] word
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [31:0] s_tdata,
    // s_tuser: [0] start_req
    input  wire  [0:0]  s_tuser,
    // m_tdata: [6:0] command, [24:7] payload_left, [29:25] code_index, [31:30] zero
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,
    // m_tuser: [1:0] kind
    output logic [1:0]  m_tuser
);
    import vdcw_pkg::*;

    localparam int CNT_MIN = $clog2(CODES_PER_WALK + 1);
    localparam int CNT_W   = (CNT_MIN > IDX_W) ? CNT_MIN : IDX_W;
    localparam logic [CNT_W-1:0] CODES_LIMIT = CNT_W'(CODES_PER_WALK);

    // Input stage
    logic              in_valid_reg;
    logic [WORD_W-1:0] in_word_reg;
    logic              in_start_reg;

    // Walk state
    logic [LEN_W-1:0]  rem_reg,  rem_next;
    logic [CNT_W-1:0]  cnt_reg,  cnt_next;
    logic [CMD_W-1:0]  last_reg, last_next;

    // Result stage
    logic              out_valid_reg;
    logic [KIND_W-1:0] kind_reg, kind_next;
    logic [CMD_W-1:0]  cmd_out_reg;
    logic [LEN_W-1:0]  left_reg;
    logic [IDX_W-1:0]  idx_reg;

    logic              out_ready;
    logic              out_load;
    logic              in_load;
    logic [LEN_W-1:0]  eff_rem;
    logic [CNT_W-1:0]  eff_cnt;
    logic [LEN_W-1:0]  payload_len;
    cmd_fields_t       fields;

    // Handshake
    assign out_ready = !out_valid_reg || m_tready;
    assign out_load  = in_valid_reg && out_ready;
    assign s_tready  = !in_valid_reg || out_ready;
    assign in_load   = s_tvalid && s_tready;

    // Field split and length decode
    assign fields.cmd = in_word_reg[30:24];
    assign fields.num = in_word_reg[23:16];
    assign fields.imm = in_word_reg[15:0];

    vdcw_len_decode u_len_decode (
        .fields      (fields),
        .payload_len (payload_len)
    );

    // Walk step
    assign eff_rem = in_start_reg ? '0 : rem_reg;
    assign eff_cnt = in_start_reg ? '0 : cnt_reg;

    always_comb begin
        rem_next  = eff_rem;
        cnt_next  = eff_cnt;
        last_next = last_reg;
        if (eff_rem != '0) begin
            kind_next = KIND_PAYLOAD;
            rem_next  = eff_rem - LEN_W'(1);
        end else if (eff_cnt >= CODES_LIMIT) begin
            kind_next = KIND_IGNORED;
        end else begin
            kind_next = KIND_COMMAND;
            last_next = fields.cmd;
            rem_next  = payload_len;
            cnt_next  = eff_cnt + CNT_W'(1);
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            cnt_reg       <= '0;
            last_reg      <= '0;
        end else begin
            if (in_load) begin
                in_valid_reg <= 1'b1;
            end else if (out_load) begin
                in_valid_reg <= 1'b0;
            end
            if (out_load) begin
                out_valid_reg <= 1'b1;
                rem_reg       <= rem_next;
                cnt_reg       <= cnt_next;
                last_reg      <= last_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_load) begin
            in_word_reg  <= s_tdata;
            in_start_reg <= s_tuser[0];
        end
        if (out_load) begin
            kind_reg    <= kind_next;
            cmd_out_reg <= last_next;
            left_reg    <= rem_next;
            idx_reg     <= cnt_next[IDX_W-1:0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {2'b00, idx_reg, left_reg, cmd_out_reg};

    // Checks
    a_ignored_no_left: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_IGNORED) |-> (m_tdata[24:7] == '0))
        else $error("ignored word reports pending payload");

    a_payload_countdown: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && kind_next == KIND_PAYLOAD) |=>
            (left_reg == $past(rem_reg) - LEN_W'(1)))
        else $error("payload count did not step down by one");

    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CODES_LIMIT)
        else $error("command count passed the walk limit");

    a_start_is_command: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_load && in_start_reg) |-> (kind_next == KIND_COMMAND))
        else $error("start word not taken as a command");

endmodule

`default_nettype wire
